/* hw/rtl/ssd_pkg.sv */
`default_nettype none
package ssd_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;
  localparam int STEP_W         = 49;
  localparam logic [STEP_W-1:0] STEP_RESET = 49'd655360;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;
  localparam logic [CFG_AW-1:0] REG_MAX_STEP_SQ = 4'h0;
  localparam logic [CFG_AW-1:0] REG_INTERP_ON   = 4'h8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       sq_acc;
    logic [1:0] axis;
    logic       cand_sq;
    logic       clip_mode;
    logic       try_cand;
    logic       probe_next;
    logic       div_init;
    logic       div_step;
    logic       emit_pt;
    logic       emit_new;
  } ssd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic d_gt_m;
    logic cand_fits;
    logic probe_last;
    logic one_chunk;
    logic run_last;
  } ssd_status_t;

endpackage
`default_nettype wire

/* hw/rtl/ssd_datapath.sv */
`default_nettype none
module ssd_datapath
  import ssd_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ssd_cmd_t              cmd,
  output ssd_status_t                status,
  input  wire logic [STEP_W-1:0]     max_step_sq,
  input  wire logic [COORD_BITS-1:0] in_new_x,
  input  wire logic [COORD_BITS-1:0] in_new_y,
  input  wire logic [COORD_BITS-1:0] in_new_z,
  output logic      [COORD_BITS-1:0] out_x,
  output logic      [COORD_BITS-1:0] out_y,
  output logic      [COORD_BITS-1:0] out_z,
  output logic                       out_last_of_run,
  output logic                       out_clipped
);

  localparam int CB   = COORD_BITS;
  localparam int NW   = CB + 1;
  localparam int SW   = 2 * NW;
  localparam int CW   = $clog2(MAX_POINTS + 2);
  localparam int PW   = 2 * CW + STEP_W;
  localparam int CMPW = (PW > 64) ? PW : 64;

  logic [CB-1:0]   last_r [3];
  logic [CB-1:0]   new_r  [3];
  logic            neg_r  [3];
  logic [NW-1:0]   mag_r  [3];
  logic [NW-1:0]   num_r  [3];
  logic [CW-1:0]   rem_r  [3];
  logic [NW-1:0]   q_acc_r[3];
  logic [CW-1:0]   r_acc_r[3];
  logic [SW-1:0]   acc_r;
  logic [CW-1:0]   c_r;
  logic [CW-1:0]   cand_r;
  logic [2*CW-1:0] candsq_r;
  logic [CW-1:0]   bit_r;
  logic [CW-1:0]   i_r;
  logic            clip_r;
  logic [CB-1:0]   ox_r, oy_r, oz_r;
  logic            olast_r, oclip_r;

  logic [CB-1:0]   in_pt  [3];
  logic [NW-1:0]   diff   [3];
  logic [NW-1:0]   sel_mag;
  logic [SW-1:0]   sq;
  logic [65:0]     acc_ext;
  logic [63:0]     d64;
  logic [STEP_W-1:0] m;
  logic [CW-1:0]   cand;
  logic [PW-1:0]   prod;
  logic [CW:0]     rs     [3];
  logic            ge     [3];
  logic [CW-1:0]   rn     [3];
  logic [NW-1:0]   qn     [3];
  logic [CB-1:0]   pt     [3];
  logic [CW:0]     rsh    [3];
  logic            ge2    [3];

  assign in_pt[0] = in_new_x;
  assign in_pt[1] = in_new_y;
  assign in_pt[2] = in_new_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {in_pt[k][CB-1], in_pt[k]} - {last_r[k][CB-1], last_r[k]};
      rs[k]   = {1'b0, r_acc_r[k]} + {1'b0, rem_r[k]};
      ge[k]   = rs[k] >= {1'b0, c_r};
      rn[k]   = ge[k] ? CW'(rs[k] - {1'b0, c_r}) : CW'(rs[k]);
      qn[k]   = q_acc_r[k] + num_r[k] + NW'(ge[k]);
      pt[k]   = neg_r[k] ? last_r[k] - qn[k][CB-1:0] : last_r[k] + qn[k][CB-1:0];
      rsh[k]  = {rem_r[k], num_r[k][NW-1]};
      ge2[k]  = rsh[k] >= {1'b0, c_r};
    end
  end

  always_comb begin
    case (cmd.axis)
      2'd0:    sel_mag = mag_r[0];
      2'd1:    sel_mag = mag_r[1];
      default: sel_mag = mag_r[2];
    endcase
  end

  assign sq      = sel_mag * sel_mag;
  assign acc_ext = 66'(acc_r);
  // The distance saturates at 64 bits, which only matters for very wide coordinates.
  assign d64     = (|acc_ext[65:64]) ? '1 : acc_ext[63:0];
  assign m       = (max_step_sq == '0) ? STEP_W'(1) : max_step_sq;
  assign cand    = cmd.clip_mode ? CW'(MAX_POINTS + 1) : (c_r | bit_r);
  assign prod    = PW'(candsq_r) * PW'(m);

  assign status.d_gt_m     = d64 > 64'(m);
  assign status.cand_fits  = CMPW'(prod) <= CMPW'(d64);
  assign status.probe_last = bit_r[0];
  assign status.one_chunk  = c_r == CW'(1);
  assign status.run_last   = i_r == c_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        last_r[k] <= '0;
      end
    end else if (cmd.emit_new) begin
      for (int k = 0; k < 3; k++) begin
        last_r[k] <= new_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int k = 0; k < 3; k++) begin
        new_r[k] <= in_pt[k];
        neg_r[k] <= diff[k][NW-1];
        mag_r[k] <= diff[k][NW-1] ? NW'(0) - diff[k] : diff[k];
      end
      acc_r  <= '0;
      clip_r <= 1'b0;
      c_r    <= '0;
    end
    if (cmd.sq_acc) begin
      acc_r <= acc_r + sq;
    end
    if (cmd.cand_sq) begin
      cand_r   <= cand;
      candsq_r <= cand * cand;
      if (cmd.clip_mode) begin
        bit_r <= CW'(1) << (CW - 1);
      end
    end
    if (cmd.try_cand && status.cand_fits) begin
      if (cmd.clip_mode) begin
        c_r    <= CW'(MAX_POINTS);
        clip_r <= 1'b1;
      end else begin
        c_r <= cand_r;
      end
    end
    if (cmd.probe_next) begin
      bit_r <= bit_r >> 1;
    end
    if (cmd.div_init) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k]   <= mag_r[k];
        rem_r[k]   <= '0;
        q_acc_r[k] <= '0;
        r_acc_r[k] <= '0;
      end
      i_r <= CW'(1);
    end
    if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= ge2[k] ? CW'(rsh[k] - {1'b0, c_r}) : CW'(rsh[k]);
        num_r[k] <= {num_r[k][NW-2:0], ge2[k]};
      end
    end
    if (cmd.emit_pt) begin
      for (int k = 0; k < 3; k++) begin
        q_acc_r[k] <= qn[k];
        r_acc_r[k] <= rn[k];
      end
      i_r     <= i_r + CW'(1);
      ox_r    <= pt[0];
      oy_r    <= pt[1];
      oz_r    <= pt[2];
      olast_r <= 1'b0;
      oclip_r <= clip_r;
    end
    if (cmd.emit_new) begin
      ox_r    <= new_r[0];
      oy_r    <= new_r[1];
      oz_r    <= new_r[2];
      olast_r <= 1'b1;
      oclip_r <= clip_r;
    end
  end

  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_z           = oz_r;
  assign out_last_of_run = olast_r;
  assign out_clipped     = oclip_r;

endmodule
`default_nettype wire

/* hw/rtl/ssd_ctrl.sv */
`default_nettype none
module ssd_ctrl
  import ssd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_start_track,
  input  wire logic        interpolate_on,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ssd_cmd_t         cmd,
  input  wire ssd_status_t status
);

  localparam int NW  = COORD_BITS + 1;
  localparam int DCW = $clog2(NW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_CHK, ST_CLIP_SQ, ST_CLIP_TRY, ST_SRCH_SQ, ST_SRCH_TRY,
    ST_DIV_INIT, ST_DIV, ST_EMIT, ST_FINAL
  } state_t;

  state_t         state_r, state_nxt;
  logic [1:0]     axis_r, axis_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;

  // The output register can take a new word when empty or when drained this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          axis_nxt    = 2'd0;
          state_nxt   = (in_start_track || !interpolate_on) ? ST_FINAL : ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq_acc = 1'b1;
        axis_nxt   = axis_r + 2'd1;
        if (axis_r == 2'd2) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        state_nxt = status.d_gt_m ? ST_CLIP_SQ : ST_FINAL;
      end
      ST_CLIP_SQ: begin
        cmd.cand_sq   = 1'b1;
        cmd.clip_mode = 1'b1;
        state_nxt     = ST_CLIP_TRY;
      end
      ST_CLIP_TRY: begin
        cmd.try_cand  = 1'b1;
        cmd.clip_mode = 1'b1;
        state_nxt     = status.cand_fits ? ST_DIV_INIT : ST_SRCH_SQ;
      end
      ST_SRCH_SQ: begin
        cmd.cand_sq = 1'b1;
        state_nxt   = ST_SRCH_TRY;
      end
      ST_SRCH_TRY: begin
        cmd.try_cand = 1'b1;
        if (status.probe_last) begin
          state_nxt = ST_DIV_INIT;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = ST_SRCH_SQ;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(NW - 1)) begin
          state_nxt = status.one_chunk ? ST_FINAL : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit_pt = 1'b1;
          if (status.run_last) begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          cmd.emit_new = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.emit_pt || cmd.emit_new) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* hw/rtl/stroke_segment_subdivider.sv */
`default_nettype none
// Track point subdivider. Each input word carries a 3D point in signed Q16.8 and a
// start flag; the block answers with one or more output words, the last one flagged
// by out_last_of_run. A start word, or any word while interpolation is off, gives the
// point back alone. Otherwise the squared distance to the previous point is measured
// and, where it exceeds max_step_sq, evenly spaced points are inserted first.
// Both channels move a word at a clock edge with valid high and stall low.
// After the accepting edge the controller squares and sums the axis differences in
// three steps, compares the sum with max_step_sq, tries the clipped chunk count
// MAX_POINTS + 1 and otherwise searches the chunk count bit by bit (a squaring and a
// try per bit), then runs a divide of COORD_BITS + 1 bit-serial steps and emits one
// point per cycle while the receiver keeps stall low. A start word, or a word with
// interpolation off, goes straight to its final point; a segment within max_step_sq
// goes there after the compare.
// The block takes one word at a time: in_stall stays high until the final point of
// the previous word sits in the output register.
// When the receiver stalls, the output register holds its word and the controller
// waits. Synchronous reset clears the stored point to the origin and loads the
// register defaults (max_step_sq 655360, interpolation on).
module stroke_segment_subdivider
  import ssd_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_start_track,
  input  wire logic [COORD_BITS-1:0] in_new_x,
  input  wire logic [COORD_BITS-1:0] in_new_y,
  input  wire logic [COORD_BITS-1:0] in_new_z,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [COORD_BITS-1:0] out_x,
  output logic      [COORD_BITS-1:0] out_y,
  output logic      [COORD_BITS-1:0] out_z,
  output logic                       out_last_of_run,
  output logic                       out_clipped,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_AW-1:0]     paddr,
  input  wire logic [CFG_DW-1:0]     pwdata,
  output logic      [CFG_DW-1:0]     prdata,
  output logic                       pready
);

  logic [STEP_W-1:0] max_step_sq_r;
  logic              interp_on_r;
  logic              wr_en;
  ssd_cmd_t          cmd;
  ssd_status_t       status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_sq_r <= STEP_RESET;
      interp_on_r   <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr)
        REG_MAX_STEP_SQ: max_step_sq_r <= pwdata[STEP_W-1:0];
        REG_INTERP_ON:   interp_on_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_MAX_STEP_SQ: prdata = CFG_DW'(max_step_sq_r);
      REG_INTERP_ON:   prdata = CFG_DW'(interp_on_r);
      default:         prdata = '0;
    endcase
  end

  ssd_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_track(in_start_track),
    .interpolate_on(interp_on_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .status        (status)
  );

  ssd_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .max_step_sq    (max_step_sq_r),
    .in_new_x       (in_new_x),
    .in_new_y       (in_new_y),
    .in_new_z       (in_new_z),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_last_of_run(out_last_of_run),
    .out_clipped    (out_clipped)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import ssd_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int MAXP = MAX_POINTS_DEF;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
    logic last;
    logic clip;
  } point_t;

  // Predicts the points emitted for each accepted word and checks results in order.
  class track_scoreboard;
    point_t pending[$];
    longint prev_x, prev_y, prev_z;
    logic [STEP_W-1:0] step_sq;
    bit interp;
    int errors;

    function new();
      prev_x = 0;
      prev_y = 0;
      prev_z = 0;
      step_sq = STEP_RESET;
      interp = 1;
      errors = 0;
    endfunction

    function automatic longint sx(logic [CB-1:0] v);
      return longint'(signed'(v));
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic void push_point(longint x, longint y, longint z, logic last,
                                       logic clip);
      point_t p;
      p.x = x[CB-1:0];
      p.y = y[CB-1:0];
      p.z = z[CB-1:0];
      p.last = last;
      p.clip = clip;
      pending.push_back(p);
    endfunction

    function void note_word(logic start, logic [CB-1:0] ix, logic [CB-1:0] iy,
                            logic [CB-1:0] iz);
      longint nx, ny, nz, vx, vy, vz, c;
      longint unsigned dist_sq, m, chunks;
      logic clip;
      nx = sx(ix);
      ny = sx(iy);
      nz = sx(iz);
      clip = 0;
      if (!start && interp) begin
        vx = nx - prev_x;
        vy = ny - prev_y;
        vz = nz - prev_z;
        // Coordinates are 24 bits, so the squared sum cannot overflow 64 bits.
        dist_sq = vx * vx + vy * vy + vz * vz;
        m = (step_sq == 0) ? 1 : step_sq;
        if (dist_sq > m) begin
          chunks = root_floor(dist_sq / m);
          if (chunks > MAXP) begin
            chunks = MAXP;
            clip = 1;
          end
          c = chunks;
          for (longint i = 1; i < c; i++)
            push_point(prev_x + (vx * i) / c, prev_y + (vy * i) / c,
                       prev_z + (vz * i) / c, 1'b0, clip);
        end
      end
      push_point(nx, ny, nz, 1'b1, clip);
      prev_x = nx;
      prev_y = ny;
      prev_z = nz;
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h z=%h", $time, got.x, got.y, got.z);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: out_last_of_run expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
      if (got.clip !== want.clip) begin
        $display("%0t: out_clipped expected %b actual %b", $time, want.clip, got.clip);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_start_track = 0;
  logic [CB-1:0] in_new_x = '0, in_new_y = '0, in_new_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [CB-1:0] out_x, out_y, out_z;
  logic out_last_of_run, out_clipped;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  track_scoreboard track_sb = new();
  longint cycles = 0;
  int hold_off = 0;
  bit stall_random = 1;

  always #6 clk = ~clk;

  stroke_segment_subdivider DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_start_track, .in_new_x, .in_new_y, .in_new_z,
    .out_valid, .out_stall, .out_x, .out_y, .out_z, .out_last_of_run, .out_clipped,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Check results and drive the receiver's stall pattern.
  always @(posedge clk) begin
    point_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x = out_x;
      got.y = out_y;
      got.z = out_z;
      got.last = out_last_of_run;
      got.clip = out_clipped;
      track_sb.check_point(got);
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else if (stall_random) begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end else begin
      out_stall <= 0;
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == REG_MAX_STEP_SQ) track_sb.step_sq = value[STEP_W-1:0];
    else track_sb.interp = value[0];
  endtask

  // Offer one word; valid stays high when the next word follows at once.
  task automatic send_word(logic start, logic [CB-1:0] x, logic [CB-1:0] y,
                           logic [CB-1:0] z, bit keep);
    in_valid <= 1;
    in_start_track <= start;
    in_new_x <= x;
    in_new_y <= y;
    in_new_z <= z;
    do @(posedge clk); while (in_stall);
    track_sb.note_word(start, x, y, z);
    if (!keep) in_valid <= 0;
  endtask

  task automatic drain();
    while (track_sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] near(logic [CB-1:0] base, int span);
    return base + CB'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic random_words(int count, int span);
    int left;
    int burst;
    logic [CB-1:0] px, py, pz;
    left = count;
    px = $urandom;
    py = $urandom;
    pz = $urandom;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      if (burst > left) burst = left;
      for (int k = 0; k < burst; k++) begin
        logic st;
        st = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 7) == 0) begin
          px = $urandom;
          py = $urandom;
          pz = $urandom;
        end else begin
          px = near(px, span);
          py = near(py, span);
          pz = near(pz, span);
        end
        send_word(st, px, py, pz, k != burst - 1);
      end
      left -= burst;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Continue without a start word uses the origin as the previous point.
    send_word(0, 24'sd2000, -24'sd1500, 24'sd700, 1);
    send_word(1, CMAX, CMAX, CMAX, 1);
    send_word(0, CMIN, CMIN, CMIN, 1);
    send_word(0, CMAX, CMIN, CMAX, 1);
    send_word(0, 24'd0, 24'd0, 24'd0, 1);
    send_word(0, 24'd100, 24'd0, 24'd0, 1);
    send_word(1, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 1);
    send_word(0, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 0);
    drain();

    // A zero step register acts as one.
    write_reg(REG_MAX_STEP_SQ, 64'd0);
    send_word(0, 24'd1, 24'd0, 24'd0, 1);
    send_word(0, 24'd3, 24'd0, 24'd0, 1);
    send_word(0, 24'd40, 24'd30, 24'd9, 0);
    drain();
    write_reg(REG_MAX_STEP_SQ, {{(CFG_DW-STEP_W){1'b0}}, {STEP_W{1'b1}}});
    send_word(0, CMIN, CMIN, CMIN, 1);
    send_word(0, CMAX, CMAX, CMAX, 0);
    drain();
    write_reg(REG_INTERP_ON, 64'd0);
    send_word(0, CMIN, 24'd5, CMAX, 1);
    send_word(0, 24'd0, 24'd0, 24'd0, 0);
    drain();

    // Long receiver hold-off while words keep coming.
    write_reg(REG_INTERP_ON, 64'd1);
    write_reg(REG_MAX_STEP_SQ, 64'd4000);
    hold_off = 300;
    random_words(15, 2000);
    drain();

    write_reg(REG_MAX_STEP_SQ, 64'd655360);
    random_words(70, 4000);
    drain();
    write_reg(REG_MAX_STEP_SQ, 64'd50);
    random_words(50, 300);
    drain();
    write_reg(REG_INTERP_ON, 64'd0);
    random_words(25, 100000);
    drain();
    write_reg(REG_INTERP_ON, 64'd1);
    write_reg(REG_MAX_STEP_SQ, 64'd1 << 30);
    stall_random = 0;
    random_words(20, 1 << 22);
    stall_random = 1;
    drain();
    write_reg(REG_MAX_STEP_SQ, 64'd1);
    random_words(30, 20);
    drain();

    if (track_sb.errors == 0 && track_sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
